/* design/sde_pkg.sv */
// Shared types, constants, helpers and the sequencer program of the stereo echo.
`timescale 1ns / 1ps
`default_nettype none

package sde_pkg;

    // Fixed field widths.
    localparam int SAMPLE_W  = 24;
    localparam int OFFSET_W  = 18;
    localparam int GAIN_W    = 25;
    localparam int GSTART_W  = 24;
    localparam int BSTEP_W   = 25;
    localparam int COEF_W    = 26;
    localparam int CFG_W     = 26;
    localparam int CFG_IDX_W = 3;

    // Datapath widths.
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int MUL_W  = 27;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;

    localparam int FRAC_GAIN = 24;
    localparam int FRAC_COEF = 22;

    localparam logic [GAIN_W-1:0] RATIO_ONE = GAIN_W'(1) << FRAC_GAIN;
    localparam logic [GAIN_W-1:0] GAIN_MAX  = {GAIN_W{1'b1}};

    localparam logic signed [ACC_W-1:0] HALF_GAIN = ACC_W'(1) <<< (FRAC_GAIN - 1);
    localparam logic signed [ACC_W-1:0] HALF_COEF = ACC_W'(1) <<< (FRAC_COEF - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI    = (ACC_W'(1) <<< (SAMPLE_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO    = -SAT_HI - ACC_W'(1);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAP_START  = 3'd0,
        REG_TAP_END    = 3'd1,
        REG_GAIN_START = 3'd2,
        REG_GAIN_STEP  = 3'd3,
        REG_BLEND_STEP = 3'd4,
        REG_SHELF_B0   = 3'd5,
        REG_SHELF_B1   = 3'd6,
        REG_SHELF_A1   = 3'd7
    } cfg_reg_e;

    // Multiplier operand pairs.
    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DIFF_BLEND,
        MUL_TAP_GAIN,
        MUL_B0_TAP,
        MUL_B1_PIN,
        MUL_A1_POUT
    } mul_sel_e;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } acc_op_e;

    // How the step counter moves after a step.
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_WAIT_IN,
        SEQ_WAIT_OUT,
        SEQ_JUMP
    } seq_e;

    localparam int STEP_W = 4;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MBLEND = 4'd2;
    localparam logic [STEP_W-1:0] STEP_BLEND  = 4'd3;
    localparam logic [STEP_W-1:0] STEP_MGAIN  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_TAP    = 4'd5;
    localparam logic [STEP_W-1:0] STEP_MB0    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_MB1    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_MA1    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_ACC    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SHELF  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_FIN    = 4'd11;

    typedef struct packed {
        mul_sel_e          mul_sel;
        acc_op_e           acc_op;
        logic              ld_diff;
        logic              ld_blend;
        logic              ld_tap;
        logic              ld_y;
        logic              fin;
        seq_e              seq;
        logic [STEP_W-1:0] target;
    } ctrl_t;

    // Program ROM: one control word per step.
    function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
        ctrl_t cw;
        cw = '0;
        cw.mul_sel = MUL_NONE;
        cw.acc_op  = ACC_HOLD;
        cw.seq     = SEQ_NEXT;
        cw.target  = STEP_IDLE;
        case (step)
            STEP_IDLE:   cw.seq = SEQ_WAIT_IN;
            STEP_DIFF:   cw.ld_diff = 1'b1;
            STEP_MBLEND: cw.mul_sel = MUL_DIFF_BLEND;
            STEP_BLEND:  cw.ld_blend = 1'b1;
            STEP_MGAIN:  cw.mul_sel = MUL_TAP_GAIN;
            STEP_TAP:    cw.ld_tap = 1'b1;
            STEP_MB0:    cw.mul_sel = MUL_B0_TAP;
            STEP_MB1:
            begin
                cw.mul_sel = MUL_B1_PIN;
                cw.acc_op  = ACC_LOAD;
            end
            STEP_MA1:
            begin
                cw.mul_sel = MUL_A1_POUT;
                cw.acc_op  = ACC_ADD;
            end
            STEP_ACC:    cw.acc_op = ACC_SUB;
            STEP_SHELF:  cw.ld_y = 1'b1;
            STEP_FIN:
            begin
                cw.fin    = 1'b1;
                cw.seq    = SEQ_WAIT_OUT;
                cw.target = STEP_IDLE;
            end
            default:
            begin
                cw.seq    = SEQ_JUMP;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [ACC_W-1:0] v
    );
        logic signed [SAMPLE_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[SAMPLE_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/sde_channels.sv */
// Handshake channels for input frames and result frames of the stereo echo.
`timescale 1ns / 1ps
`default_nettype none

interface sde_in_if
    import sde_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       tick_start;

    modport source (output valid, output left_in, output right_in, output tick_start,
                    input ready);
    modport sink (input valid, input left_in, input right_in, input tick_start,
                  output ready);
endinterface

interface sde_out_if
    import sde_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

/* design/stereo_damped_echo.sv */
// Stereo feedback echo with two blended taps, running gain and a shelf filter per channel.
// A 12-step program shares one multiplier per channel over five products. A word is
// taken only in the idle step, so a new word waits until the last one has finished;
// the last step waits while a result is held.
// Reset: a clearing pass writes zero to all HISTORY_DEPTH entries, one a cycle, and no
// word is taken during it; configuration writes are taken at any time.
`timescale 1ns / 1ps
`default_nettype none

module stereo_damped_echo
    import sde_pkg::*;
#(
    parameter int HISTORY_DEPTH = 262144
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    sde_in_if.sink                    samples,
    sde_out_if.source                 results
);

    // HISTORY_DEPTH must be a power of two, which the block does not check; addresses wrap naturally.
    localparam int ADDR_W = $clog2(HISTORY_DEPTH);
    localparam int EXT_W  = ADDR_W + OFFSET_W;
    localparam int MEM_W  = 2 * SAMPLE_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(HISTORY_DEPTH - 1);

    // Configuration registers.
    logic        [OFFSET_W-1:0] tap_start_reg;
    logic        [OFFSET_W-1:0] tap_end_reg;
    logic        [GSTART_W-1:0] gain_start_reg;
    logic        [GSTART_W-1:0] gain_step_reg;
    logic        [BSTEP_W-1:0]  blend_step_reg;
    logic signed [COEF_W-1:0]   b0_reg;
    logic signed [COEF_W-1:0]   b1_reg;
    logic signed [COEF_W-1:0]   a1_reg;

    // Sequencer and running state.
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              clr_active_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] wp_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic [GAIN_W-1:0] blend_reg;
    logic              out_valid_reg;

    // History memory, left sample in the upper half.
    logic [MEM_W-1:0]  hist_mem [HISTORY_DEPTH];
    logic [MEM_W-1:0]  rd_s_reg;
    logic [MEM_W-1:0]  rd_e_reg;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [MEM_W-1:0]  mem_wdata;
    logic [EXT_W-1:0]  off_s_ext;
    logic [EXT_W-1:0]  off_e_ext;
    logic [ADDR_W-1:0] addr_s;
    logic [ADDR_W-1:0] addr_e;

    // Per-channel datapath, channel 0 is left.
    logic signed [SAMPLE_W-1:0] x_reg    [2];
    logic signed [SAMPLE_W-1:0] a_reg    [2];
    logic signed [DIFF_W-1:0]   diff_reg [2];
    logic signed [DIFF_W-1:0]   bl_reg   [2];
    logic signed [PROD_W-1:0]   prod_reg [2];
    logic signed [ACC_W-1:0]    acc_reg  [2];
    logic signed [SAMPLE_W-1:0] tap_reg  [2];
    logic signed [SAMPLE_W-1:0] y_reg    [2];
    logic signed [SAMPLE_W-1:0] pin_reg  [2];
    logic signed [SAMPLE_W-1:0] pout_reg [2];
    logic signed [SAMPLE_W-1:0] out_reg  [2];

    logic signed [MUL_W-1:0]    mul_a    [2];
    logic signed [MUL_W-1:0]    mul_b    [2];
    logic signed [PROD_W-1:0]   prod_next[2];
    logic signed [ACC_W-1:0]    prod_x   [2];
    logic signed [ACC_W-1:0]    r24      [2];
    logic signed [ACC_W-1:0]    r22      [2];
    logic signed [ACC_W-1:0]    sum_x    [2];
    logic signed [SAMPLE_W-1:0] res_next [2];
    logic signed [SAMPLE_W-1:0] rd_s_smp [2];
    logic signed [SAMPLE_W-1:0] rd_e_smp [2];

    ctrl_t              cw;
    logic               accept;
    logic               out_free;
    logic               fin_go;
    logic [GAIN_W:0]    gain_sum;
    logic [GAIN_W:0]    blend_sum;
    logic [GAIN_W-1:0]  gain_next;
    logic [GAIN_W-1:0]  blend_next;

    assign cw       = ucode(step_reg);
    assign samples.ready = (cw.seq == SEQ_WAIT_IN) && !clr_active_reg;
    assign accept   = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;
    assign fin_go   = cw.fin && out_free;

    assign results.valid     = out_valid_reg;
    assign results.left_out  = out_reg[0];
    assign results.right_out = out_reg[1];

    // Tap addresses: offsets taken modulo the depth, counted back from the write position.
    assign off_s_ext = EXT_W'(tap_start_reg);
    assign off_e_ext = EXT_W'(tap_end_reg);
    assign addr_s    = wp_reg - off_s_ext[ADDR_W-1:0];
    assign addr_e    = wp_reg - off_e_ext[ADDR_W-1:0];

    assign rd_s_smp[0] = rd_s_reg[MEM_W-1:SAMPLE_W];
    assign rd_s_smp[1] = rd_s_reg[SAMPLE_W-1:0];
    assign rd_e_smp[0] = rd_e_reg[MEM_W-1:SAMPLE_W];
    assign rd_e_smp[1] = rd_e_reg[SAMPLE_W-1:0];

    assign mem_we    = clr_active_reg || fin_go;
    assign mem_waddr = clr_active_reg ? clr_addr_reg : wp_reg;
    assign mem_wdata = clr_active_reg ? '0 : {res_next[0], res_next[1]};

    always_comb
    begin
        case (cw.seq)
            SEQ_NEXT:     step_next = step_reg + STEP_W'(1);
            SEQ_WAIT_IN:  step_next = accept ? step_reg + STEP_W'(1) : step_reg;
            SEQ_WAIT_OUT: step_next = out_free ? cw.target : step_reg;
            SEQ_JUMP:     step_next = cw.target;
            default:      step_next = STEP_IDLE;
        endcase
    end

    always_comb
    begin
        gain_sum  = {1'b0, gain_reg} + (GAIN_W + 1)'(gain_step_reg);
        blend_sum = {1'b0, blend_reg} + (GAIN_W + 1)'(blend_step_reg);
        gain_next = gain_sum[GAIN_W] ? GAIN_MAX : gain_sum[GAIN_W-1:0];
        if (blend_sum > (GAIN_W + 1)'(RATIO_ONE))
        begin
            blend_next = RATIO_ONE;
        end
        else
        begin
            blend_next = blend_sum[GAIN_W-1:0];
        end
    end

    // Shared multiplier operands and rounding per channel.
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            case (cw.mul_sel)
                MUL_DIFF_BLEND:
                begin
                    mul_a[l] = MUL_W'(diff_reg[l]);
                    mul_b[l] = {2'b00, blend_reg};
                end
                MUL_TAP_GAIN:
                begin
                    mul_a[l] = MUL_W'(bl_reg[l]);
                    mul_b[l] = {2'b00, gain_reg};
                end
                MUL_B0_TAP:
                begin
                    mul_a[l] = MUL_W'(b0_reg);
                    mul_b[l] = MUL_W'(tap_reg[l]);
                end
                MUL_B1_PIN:
                begin
                    mul_a[l] = MUL_W'(b1_reg);
                    mul_b[l] = MUL_W'(pin_reg[l]);
                end
                MUL_A1_POUT:
                begin
                    mul_a[l] = MUL_W'(a1_reg);
                    mul_b[l] = MUL_W'(pout_reg[l]);
                end
                default:
                begin
                    mul_a[l] = '0;
                    mul_b[l] = '0;
                end
            endcase
            prod_next[l] = mul_a[l] * mul_b[l];
            prod_x[l]    = ACC_W'(prod_reg[l]);
            r24[l]       = (prod_x[l] + HALF_GAIN) >>> FRAC_GAIN;
            r22[l]       = (acc_reg[l] + HALF_COEF) >>> FRAC_COEF;
            sum_x[l]     = ACC_W'(x_reg[l]) + ACC_W'(y_reg[l]);
            res_next[l]  = sat_sample(sum_x[l]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_start_reg  <= OFFSET_W'(1);
            tap_end_reg    <= OFFSET_W'(1);
            gain_start_reg <= '0;
            gain_step_reg  <= '0;
            blend_step_reg <= '0;
            b0_reg         <= '0;
            b1_reg         <= '0;
            a1_reg         <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_TAP_START:  tap_start_reg  <= cfg_data[OFFSET_W-1:0];
                REG_TAP_END:    tap_end_reg    <= cfg_data[OFFSET_W-1:0];
                REG_GAIN_START: gain_start_reg <= cfg_data[GSTART_W-1:0];
                REG_GAIN_STEP:  gain_step_reg  <= cfg_data[GSTART_W-1:0];
                REG_BLEND_STEP: blend_step_reg <= cfg_data[BSTEP_W-1:0];
                REG_SHELF_B0:   b0_reg         <= cfg_data[COEF_W-1:0];
                REG_SHELF_B1:   b1_reg         <= cfg_data[COEF_W-1:0];
                REG_SHELF_A1:   a1_reg         <= cfg_data[COEF_W-1:0];
                default:        ;
            endcase
        end
    end

    // Control and running state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_IDLE;
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            wp_reg         <= '0;
            gain_reg       <= '0;
            blend_reg      <= '0;
            out_valid_reg  <= 1'b0;
            for (int l = 0; l < 2; l++)
            begin
                pin_reg[l]  <= '0;
                pout_reg[l] <= '0;
            end
        end
        else
        begin
            step_reg <= step_next;
            if (clr_active_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept && samples.tick_start)
            begin
                gain_reg  <= GAIN_W'(gain_start_reg);
                blend_reg <= '0;
            end
            if (fin_go)
            begin
                wp_reg        <= wp_reg + ADDR_W'(1);
                gain_reg      <= gain_next;
                blend_reg     <= blend_next;
                out_valid_reg <= 1'b1;
                for (int l = 0; l < 2; l++)
                begin
                    pin_reg[l]  <= tap_reg[l];
                    pout_reg[l] <= y_reg[l];
                end
            end
            else if (results.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        for (int l = 0; l < 2; l++)
        begin
            if (cw.ld_diff)
            begin
                a_reg[l]    <= rd_s_smp[l];
                diff_reg[l] <= DIFF_W'(rd_e_smp[l]) - DIFF_W'(rd_s_smp[l]);
            end
            if (cw.mul_sel != MUL_NONE)
            begin
                prod_reg[l] <= prod_next[l];
            end
            if (cw.ld_blend)
            begin
                bl_reg[l] <= DIFF_W'(a_reg[l]) + r24[l][DIFF_W-1:0];
            end
            if (cw.ld_tap)
            begin
                tap_reg[l] <= sat_sample(r24[l]);
            end
            case (cw.acc_op)
                ACC_LOAD: acc_reg[l] <= prod_x[l];
                ACC_ADD:  acc_reg[l] <= acc_reg[l] + prod_x[l];
                ACC_SUB:  acc_reg[l] <= acc_reg[l] - prod_x[l];
                default:  ;
            endcase
            if (cw.ld_y)
            begin
                y_reg[l] <= sat_sample(r22[l]);
            end
            if (fin_go)
            begin
                out_reg[l] <= res_next[l];
            end
        end
        if (accept)
        begin
            x_reg[0] <= samples.left_in;
            x_reg[1] <= samples.right_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            hist_mem[mem_waddr] <= mem_wdata;
        end
        if (accept)
        begin
            rd_s_reg <= hist_mem[addr_s];
            rd_e_reg <= hist_mem[addr_e];
        end
    end

`ifndef SYNTHESIS
    a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !samples.ready)
        else $error("word taken during the clearing pass");

    a_accept_starts_program: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (step_reg == STEP_DIFF))
        else $error("program did not start after an accepted word");

    a_finish_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        fin_go |=> results.valid)
        else $error("finished word not presented on the result channel");

    a_blend_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        blend_reg <= RATIO_ONE)
        else $error("blend ratio above one");
`endif

endmodule

`default_nettype wire

/* bench/stereo_damped_echo_test.sv */
// Self-checking testbench for the stereo feedback echo with shelf damping.
`timescale 1ns / 1ps

import sde_pkg::*;

class echo_tracker #(int DEPTH = 262144);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
    } frame_t;

    localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_LO = -SAMPLE_HI - 1;
    localparam longint RATIO_FULL = longint'(1) <<< FRAC_GAIN;
    localparam longint GAIN_TOP = (longint'(1) <<< GAIN_W) - 1;

    bit signed [SAMPLE_W-1:0] hist_left[DEPTH];
    bit signed [SAMPLE_W-1:0] hist_right[DEPTH];
    int     write_pos;
    longint run_gain;
    longint run_ratio;
    longint prev_tap[2];
    longint prev_shelf[2];

    longint tap_start;
    longint tap_end;
    longint gain_start;
    longint gain_step;
    longint blend_step;
    longint coef_b0;
    longint coef_b1;
    longint coef_a1;

    frame_t pending_frames[$];
    int     frames_taken;
    int     frames_seen;
    int     errors;

    function new();
        write_pos = 0;
        run_gain = 0;
        run_ratio = 0;
        prev_tap = '{0, 0};
        prev_shelf = '{0, 0};
        tap_start = 1;
        tap_end = 1;
        gain_start = 0;
        gain_step = 0;
        blend_step = 0;
        coef_b0 = 0;
        coef_b1 = 0;
        coef_a1 = 0;
        frames_taken = 0;
        frames_seen = 0;
        errors = 0;
    endfunction

    function void report_mismatch(string msg);
        errors++;
        $display("MISMATCH: %s", msg);
    endfunction

    function int outstanding();
        return pending_frames.size();
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_W-1:0] v);
        case (idx)
            REG_TAP_START:  tap_start = v[OFFSET_W-1:0];
            REG_TAP_END:    tap_end = v[OFFSET_W-1:0];
            REG_GAIN_START: gain_start = v[GSTART_W-1:0];
            REG_GAIN_STEP:  gain_step = v[GSTART_W-1:0];
            REG_BLEND_STEP: blend_step = v[BSTEP_W-1:0];
            REG_SHELF_B0:   coef_b0 = longint'($signed(v));
            REG_SHELF_B1:   coef_b1 = longint'($signed(v));
            REG_SHELF_A1:   coef_a1 = longint'($signed(v));
            default:        ;
        endcase
    endfunction

    // Rounds half up, that is toward plus infinity on ties.
    function longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function longint clip(longint v);
        if (v > SAMPLE_HI)
        begin
            return SAMPLE_HI;
        end
        if (v < SAMPLE_LO)
        begin
            return SAMPLE_LO;
        end
        return v;
    endfunction

    function longint shelf_echo(int ch, longint x, longint near_tap, longint far_tap);
        longint mix;
        longint tap;
        longint acc;
        longint y;
        mix = near_tap + round_shift((far_tap - near_tap) * run_ratio, FRAC_GAIN);
        tap = clip(round_shift(mix * run_gain, FRAC_GAIN));
        acc = coef_b0 * tap + coef_b1 * prev_tap[ch] - coef_a1 * prev_shelf[ch];
        y = clip(round_shift(acc, FRAC_COEF));
        prev_tap[ch] = tap;
        prev_shelf[ch] = y;
        return clip(x + y);
    endfunction

    function void take_frame(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r,
                             logic tick);
        int     near_idx;
        int     far_idx;
        longint yl;
        longint yr;
        frame_t want;
        if (tick)
        begin
            run_gain = gain_start;
            run_ratio = 0;
        end
        near_idx = (write_pos + DEPTH - int'(tap_start % DEPTH)) % DEPTH;
        far_idx = (write_pos + DEPTH - int'(tap_end % DEPTH)) % DEPTH;
        yl = shelf_echo(0, longint'(l), hist_left[near_idx], hist_left[far_idx]);
        yr = shelf_echo(1, longint'(r), hist_right[near_idx], hist_right[far_idx]);
        hist_left[write_pos] = yl[SAMPLE_W-1:0];
        hist_right[write_pos] = yr[SAMPLE_W-1:0];
        write_pos = (write_pos + 1) % DEPTH;
        run_ratio = run_ratio + blend_step;
        if (run_ratio > RATIO_FULL)
        begin
            run_ratio = RATIO_FULL;
        end
        run_gain = run_gain + gain_step;
        if (run_gain > GAIN_TOP)
        begin
            run_gain = GAIN_TOP;
        end
        want.left = yl[SAMPLE_W-1:0];
        want.right = yr[SAMPLE_W-1:0];
        pending_frames.push_back(want);
        frames_taken++;
    endfunction

    function void check_output(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        frame_t want;
        frames_seen++;
        if (pending_frames.size() == 0)
        begin
            report_mismatch($sformatf("result word %0d came with no frame waiting", frames_seen));
            return;
        end
        want = pending_frames.pop_front();
        if (l !== want.left)
        begin
            report_mismatch($sformatf("word %0d left_out %0d, expected %0d",
                                      frames_seen, l, want.left));
        end
        if (r !== want.right)
        begin
            report_mismatch($sformatf("word %0d right_out %0d, expected %0d",
                                      frames_seen, r, want.right));
        end
    endfunction

endclass

module stereo_damped_echo_test;

    localparam int ECHO_DEPTH = 262144;
    localparam int PHASES = 8;
    localparam int PHASE_FRAMES = 150;
    localparam int PAUSE_AT = 50;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_LIMIT = 5000;
    localparam longint TIMEOUT_NS = 12_000_000;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 24'sh7FFFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 24'sh800000;
    localparam int TAP_MAX = 262143;
    localparam int GAIN_START_MAX = 15099494;
    localparam int GAIN_STEP_MAX = 16777215;
    localparam int BLEND_STEP_MAX = 16777216;
    localparam int COEF_MAX = 33554431;
    localparam int COEF_MIN = -33554432;
    localparam int COEF_ONE = 4194304;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    cfg_reg_e             cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    sde_in_if  samples();
    sde_out_if results();

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    echo_tracker #(ECHO_DEPTH) tracker;

    stereo_damped_echo #(
        .HISTORY_DEPTH(ECHO_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples),
        .results   (results)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #4 clk = ~clk;
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d words outstanding", tracker.outstanding());
        $display("== FAIL ==");
        $finish;
    end

    // Result side: ready changes on the falling edge, words are taken on the rising edge.
    initial
    begin
        results.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            results.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && results.valid && results.ready)
            begin
                tracker.check_output(results.left_out, results.right_out);
            end
        end
    end

    task automatic send_frame(input logic signed [SAMPLE_W-1:0] lsamp,
                              input logic signed [SAMPLE_W-1:0] rsamp,
                              input logic tick);
        while ($urandom_range(99) < send_idle_pct)
        begin
            samples.valid <= 1'b0;
            @(negedge clk);
        end
        samples.valid <= 1'b1;
        samples.left_in <= lsamp;
        samples.right_in <= rsamp;
        samples.tick_start <= tick;
        do
        begin
            @(posedge clk);
        end
        while (!samples.ready);
        tracker.take_frame(lsamp, rsamp, tick);
        @(negedge clk);
    endtask

    task automatic hold_until_drained();
        samples.valid <= 1'b0;
        @(negedge clk);
        while (tracker.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic write_reg(input cfg_reg_e idx, input logic [CFG_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        tracker.set_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_W-1:0] start_off, input logic [CFG_W-1:0] end_off,
                                  input logic [CFG_W-1:0] g0, input logic [CFG_W-1:0] gstep,
                                  input logic [CFG_W-1:0] bstep, input logic [CFG_W-1:0] b0,
                                  input logic [CFG_W-1:0] b1, input logic [CFG_W-1:0] a1);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        write_reg(REG_TAP_START, start_off);
        write_reg(REG_TAP_END, end_off);
        write_reg(REG_GAIN_START, g0);
        write_reg(REG_GAIN_STEP, gstep);
        write_reg(REG_BLEND_STEP, bstep);
        write_reg(REG_SHELF_B0, b0);
        write_reg(REG_SHELF_B1, b1);
        write_reg(REG_SHELF_A1, a1);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        logic signed [SAMPLE_W-1:0] v;
        case ($urandom_range(15))
            0:       v = SAMPLE_MAX;
            1:       v = SAMPLE_MIN;
            2, 3, 4: v = SAMPLE_W'(int'($urandom_range(0, 511)) - 256);
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef(input int unsigned span);
        logic signed [CFG_W-1:0] v;
        v = CFG_W'($urandom_range(0, span));
        if ($urandom_range(1) != 0)
        begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [CFG_W-1:0] pick_offset();
        if ($urandom_range(5) == 0)
        begin
            return CFG_W'($urandom_range(1, TAP_MAX));
        end
        // Mostly short delays, so the taps land on words already sent.
        return CFG_W'($urandom_range(1, 1200));
    endfunction

    task automatic apply_random_settings(input int phase);
        logic [CFG_W-1:0] gstep;
        logic [CFG_W-1:0] bstep;
        bit               wild;
        case ($urandom_range(3))
            0:       gstep = '0;
            1:       gstep = CFG_W'($urandom_range(0, 255));
            2:       gstep = CFG_W'($urandom_range(0, 65535));
            default: gstep = CFG_W'($urandom_range(0, GAIN_STEP_MAX));
        endcase
        case ($urandom_range(3))
            0:       bstep = '0;
            1:       bstep = CFG_W'($urandom_range(0, 16384));
            2:       bstep = CFG_W'($urandom_range(0, 1048576));
            default: bstep = CFG_W'($urandom_range(0, BLEND_STEP_MAX));
        endcase
        // Every third phase uses the full coefficient range and saturates hard.
        wild = (phase % 3 == 2);
        apply_settings(pick_offset(), pick_offset(), CFG_W'($urandom_range(0, GAIN_START_MAX)),
                       gstep, bstep,
                       pick_coef(wild ? COEF_MAX : COEF_ONE),
                       pick_coef(wild ? COEF_MAX : COEF_ONE / 2),
                       pick_coef(wild ? COEF_MAX : COEF_ONE / 2));
    endtask

    initial
    begin
        int spin;
        tracker = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_TAP_START;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.left_in = '0;
        samples.right_in = '0;
        samples.tick_start = 1'b0;
        send_idle_pct = 7;
        recv_idle_pct = 52;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: zero gain, so each word passes straight through.
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b1);
        send_frame('0, '0, 1'b0);
        send_frame(-24'sd1, 24'sd1, 1'b0);
        send_frame(24'sh555555, 24'shAAAAAA, 1'b0);
        send_frame(24'shAAAAAA, 24'sh555555, 1'b1);

        // Largest gain, step and ratio with extreme coefficients: every stage saturates.
        apply_settings(CFG_W'(1), CFG_W'(2), CFG_W'(GAIN_START_MAX), CFG_W'(GAIN_STEP_MAX),
                       CFG_W'(BLEND_STEP_MAX), CFG_W'(COEF_MAX), CFG_W'(COEF_MIN),
                       CFG_W'(COEF_MIN));
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b1);
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b0);
        send_frame(SAMPLE_MIN, SAMPLE_MIN, 1'b0);
        send_frame('0, SAMPLE_MAX, 1'b0);
        send_frame(SAMPLE_MIN, '0, 1'b1);
        send_frame(24'sd1000, -24'sd1000, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);

        // A zero offset reads the slot about to be written; the longest delay reads far back.
        apply_settings('0, CFG_W'(TAP_MAX), '0, CFG_W'(1048576), '0, CFG_W'(COEF_MIN),
                       CFG_W'(COEF_MAX), CFG_W'(COEF_MAX));
        send_frame(SAMPLE_MAX, SAMPLE_MIN, 1'b1);
        send_frame(SAMPLE_MIN, SAMPLE_MAX, 1'b0);
        send_frame(24'sd12345, -24'sd54321, 1'b0);
        send_frame('0, '0, 1'b0);
        send_frame(SAMPLE_MAX, SAMPLE_MAX, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 3)
            begin
                send_idle_pct = 52;
                recv_idle_pct = 7;
            end
            else if (phase == 6)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            apply_random_settings(phase);
            for (int n = 0; n < PHASE_FRAMES; n++)
            begin
                if (n == PAUSE_AT)
                begin
                    hold_until_drained();
                end
                send_frame(pick_sample(), pick_sample(), (n == 0) || ($urandom_range(24) == 0));
            end
        end

        samples.valid <= 1'b0;
        for (spin = 0; spin < DRAIN_LIMIT && tracker.outstanding() != 0; spin++)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (tracker.outstanding() != 0)
        begin
            tracker.report_mismatch($sformatf("%0d words never came out",
                                              tracker.outstanding()));
        end
        if (tracker.errors == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
